[hdl/rssv_pkg.sv]
// Shared types and constants for the RLE sprite stream validator.
package rssv_pkg;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [7:0] CODE_END = 8'hff;
  localparam logic [7:0] CODE_ROW = 8'hfe;

  // register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_LENGTH = 2'd2,
    REG_NONE   = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    V_CHECK   = 2'd0,
    V_VALID   = 2'd1,
    V_INVALID = 2'd2,
    V_UNUSED  = 2'd3
  } verdict_t;

  typedef enum logic [2:0] {
    PH_CODE  = 3'b001,
    PH_COUNT = 3'b010,
    PH_SKIP  = 3'b100
  } phase_t;

endpackage

[hdl/rssv_cfg_regs.sv]
// APB register file: image width, image height and data length.
module rssv_cfg_regs #(
  parameter int LENGTH_BITS = 24,
  parameter int DIM_BITS    = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rssv_pkg::ADDR_W-1:0] paddr,
  input  logic [rssv_pkg::DATA_W-1:0] pwdata,
  output logic [rssv_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output logic [DIM_BITS-1:0]         image_width,
  output logic [DIM_BITS-1:0]         image_height,
  output logic [LENGTH_BITS-1:0]      data_length
);

  // the length register only carries 24 bits
  localparam int LEN_IN = (LENGTH_BITS < 24) ? LENGTH_BITS : 24;

  logic [DIM_BITS-1:0]    width_r;
  logic [DIM_BITS-1:0]    height_r;
  logic [LENGTH_BITS-1:0] length_r;
  rssv_pkg::reg_idx_t     idx;
  logic                   wr_en;

  assign idx    = rssv_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= '0;
      height_r <= '0;
      length_r <= '0;
    end else if (wr_en) begin
      unique case (idx)
        rssv_pkg::REG_WIDTH:  width_r  <= pwdata[DIM_BITS-1:0];
        rssv_pkg::REG_HEIGHT: height_r <= pwdata[DIM_BITS-1:0];
        rssv_pkg::REG_LENGTH: length_r <= LENGTH_BITS'(pwdata[LEN_IN-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      rssv_pkg::REG_WIDTH:  prdata = rssv_pkg::DATA_W'(width_r);
      rssv_pkg::REG_HEIGHT: prdata = rssv_pkg::DATA_W'(height_r);
      rssv_pkg::REG_LENGTH: prdata = rssv_pkg::DATA_W'(length_r);
      default:              prdata = '0;
    endcase
  end

  assign image_width  = width_r;
  assign image_height = height_r;
  assign data_length  = length_r;

endmodule

[hdl/rssv_checker.sv]
// Per-byte stream check: parse state registers and next-state logic.
module rssv_checker #(
  parameter int LENGTH_BITS = 24,
  parameter int DIM_BITS    = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step_en,
  input  logic                   start,
  input  logic [7:0]             data_byte,
  input  logic [DIM_BITS-1:0]    image_width,
  input  logic [DIM_BITS-1:0]    image_height,
  input  logic [LENGTH_BITS-1:0] data_length,
  output rssv_pkg::verdict_t     verdict
);

  localparam int CW = ((DIM_BITS > 8) ? DIM_BITS : 8) + 1;
  localparam int PW = LENGTH_BITS + 1;

  rssv_pkg::phase_t       phase_r, phase_nxt, cur_phase;
  logic [LENGTH_BITS-1:0] pos_r, pos_nxt, cur_pos;
  logic [DIM_BITS-1:0]    col_r, col_nxt, cur_col;
  logic [DIM_BITS-1:0]    row_r, row_nxt, cur_row, row_inc;
  logic [7:0]             left_r, left_nxt, cur_left, left_dec;
  rssv_pkg::verdict_t     lat_r, cur_lat, res;
  logic [CW-1:0]          col_sum;
  logic                   col_over;
  logic [PW-1:0]          pos_one, pos_run, len_ext;

  always_comb begin
    cur_phase = start ? rssv_pkg::PH_CODE : phase_r;
    cur_pos   = start ? '0 : pos_r;
    cur_col   = start ? '0 : col_r;
    cur_row   = start ? '0 : row_r;
    cur_left  = start ? '0 : left_r;
    cur_lat   = start ? rssv_pkg::V_CHECK : lat_r;

    col_sum  = CW'(cur_col) + CW'(data_byte);
    col_over = col_sum > CW'(image_width);
    len_ext  = PW'(data_length);
    pos_one  = PW'(cur_pos) + PW'(1);
    pos_run  = pos_one + PW'(data_byte);
    row_inc  = cur_row + DIM_BITS'(1);
    left_dec = cur_left - 8'd1;

    phase_nxt = cur_phase;
    pos_nxt   = cur_pos;
    col_nxt   = cur_col;
    row_nxt   = cur_row;
    left_nxt  = cur_left;
    res       = cur_lat;

    if (cur_lat == rssv_pkg::V_CHECK) begin
      res = rssv_pkg::V_CHECK;
      if (image_width == '0 || image_height == '0) begin
        res = rssv_pkg::V_INVALID;
      end else begin
        unique case (cur_phase)
          rssv_pkg::PH_SKIP: begin
            left_nxt = left_dec;
            if (left_dec == 8'd0) phase_nxt = rssv_pkg::PH_CODE;
            pos_nxt = pos_one[LENGTH_BITS-1:0];
          end
          rssv_pkg::PH_COUNT: begin
            if (PW'(cur_pos) >= len_ext || col_over || pos_run >= len_ext) begin
              res = rssv_pkg::V_INVALID;
            end else begin
              col_nxt   = col_sum[DIM_BITS-1:0];
              left_nxt  = data_byte;
              phase_nxt = (data_byte == 8'd0) ? rssv_pkg::PH_CODE : rssv_pkg::PH_SKIP;
              pos_nxt   = pos_run[LENGTH_BITS-1:0];
            end
          end
          rssv_pkg::PH_CODE: begin
            if (PW'(cur_pos) >= len_ext) begin
              res = rssv_pkg::V_INVALID;
            end else if (data_byte == rssv_pkg::CODE_END) begin
              res = rssv_pkg::V_VALID;
            end else if (data_byte == rssv_pkg::CODE_ROW) begin
              if (row_inc == image_height || pos_one >= len_ext) begin
                res = rssv_pkg::V_INVALID;
              end else begin
                row_nxt = row_inc;
                col_nxt = '0;
                pos_nxt = pos_one[LENGTH_BITS-1:0];
              end
            end else begin
              // skip count; the pixel count must still fit inside the data
              if (col_over || pos_one >= len_ext) begin
                res = rssv_pkg::V_INVALID;
              end else begin
                col_nxt   = col_sum[DIM_BITS-1:0];
                phase_nxt = rssv_pkg::PH_COUNT;
                pos_nxt   = pos_one[LENGTH_BITS-1:0];
              end
            end
          end
          default: phase_nxt = rssv_pkg::PH_CODE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= rssv_pkg::PH_CODE;
      pos_r   <= '0;
      col_r   <= '0;
      row_r   <= '0;
      left_r  <= '0;
      lat_r   <= rssv_pkg::V_CHECK;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      left_r  <= left_nxt;
      lat_r   <= res;
    end
  end

  assign verdict = res;

endmodule

[hdl/rle_sprite_stream_validator_top.sv]
// Run-length sprite stream validator: top level with request pipeline.
// A byte is held in the input register; its verdict is computed from it combinationally and is
// registered into out_verdict as the byte leaves, which out_stall can hold back.
// Throughput: one byte per cycle while out_stall allows; the parse state updates as a byte leaves the input register.
// out_stall reaches in_stall combinationally through the input register's hold.
// Synchronous active-low reset clears the pipeline, the parse state and the config registers.
module rle_sprite_stream_validator_top #(
  parameter int LENGTH_BITS = 24,
  parameter int DIM_BITS    = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_start_of_image,
  input  logic [7:0]                  in_data_byte,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_verdict,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rssv_pkg::ADDR_W-1:0] paddr,
  input  logic [rssv_pkg::DATA_W-1:0] pwdata,
  output logic [rssv_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  logic [DIM_BITS-1:0]    image_width;
  logic [DIM_BITS-1:0]    image_height;
  logic [LENGTH_BITS-1:0] data_length;

  logic               s1_valid_r;
  logic               s1_start_r;
  logic [7:0]         s1_byte_r;
  logic               s1_adv;
  logic               out_valid_r;
  logic [1:0]         out_verdict_r;
  rssv_pkg::verdict_t verdict;

  rssv_cfg_regs #(
    .LENGTH_BITS(LENGTH_BITS),
    .DIM_BITS   (DIM_BITS)
  ) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .image_width (image_width),
    .image_height(image_height),
    .data_length (data_length)
  );

  // request moves on when the result register is empty or being drained
  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_start_r <= in_start_of_image;
      s1_byte_r  <= in_data_byte;
    end
  end

  rssv_checker #(
    .LENGTH_BITS(LENGTH_BITS),
    .DIM_BITS   (DIM_BITS)
  ) u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (s1_adv),
    .start       (s1_start_r),
    .data_byte   (s1_byte_r),
    .image_width (image_width),
    .image_height(image_height),
    .data_length (data_length),
    .verdict     (verdict)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_verdict_r <= verdict;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_verdict = out_verdict_r;

endmodule

[test/rle_sprite_stream_validator_top_test.sv]
// Testbench for the RLE sprite stream validator: sprite streams in, verdicts checked.
`timescale 1ns / 1ps

module rle_sprite_stream_validator_top_test;

  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 880;

  // Running parse of the byte stream; each accepted request queues the verdict it must give.
  class verdict_board;
    logic [15:0]        width_lim;
    logic [15:0]        height_lim;
    logic [23:0]        length_lim;
    rssv_pkg::phase_t   phase;
    logic [23:0]        pos;
    logic [16:0]        column;
    logic [15:0]        row;
    logic [7:0]         pixels_left;
    rssv_pkg::verdict_t verdict;
    rssv_pkg::verdict_t expected_verdicts[$];
    int                 results_seen;
    int                 errors;

    function new();
      width_lim = '0;
      height_lim = '0;
      length_lim = '0;
      results_seen = 0;
      errors = 0;
      clear_image();
    endfunction

    function void clear_image();
      phase = rssv_pkg::PH_CODE;
      pos = '0;
      column = '0;
      row = '0;
      pixels_left = '0;
      verdict = rssv_pkg::V_CHECK;
    endfunction

    function void set_limits(logic [15:0] w, logic [15:0] h, logic [23:0] l);
      width_lim = w;
      height_lim = h;
      length_lim = l;
    endfunction

    function rssv_pkg::verdict_t judge_byte(logic [7:0] b);
      logic [24:0] nxt;
      logic [16:0] col;
      logic [15:0] r;
      if (width_lim == 0 || height_lim == 0) return rssv_pkg::V_INVALID;
      if (phase == rssv_pkg::PH_SKIP) begin
        pixels_left = pixels_left - 8'd1;
        if (pixels_left == 0) phase = rssv_pkg::PH_CODE;
        pos = pos + 24'd1;
        return rssv_pkg::V_CHECK;
      end
      if (pos >= length_lim) return rssv_pkg::V_INVALID;
      nxt = {1'b0, pos} + 25'd1;
      if (phase == rssv_pkg::PH_COUNT) begin
        col = column + {9'd0, b};
        if (col > {1'b0, width_lim}) return rssv_pkg::V_INVALID;
        nxt = nxt + {17'd0, b};
        // the pixel run must leave room for another code byte
        if (nxt >= {1'b0, length_lim}) return rssv_pkg::V_INVALID;
        column = col;
        pixels_left = b;
        if (b == 0) phase = rssv_pkg::PH_CODE;
        else phase = rssv_pkg::PH_SKIP;
        pos = nxt[23:0];
        return rssv_pkg::V_CHECK;
      end
      if (b == rssv_pkg::CODE_END) return rssv_pkg::V_VALID;
      if (b == rssv_pkg::CODE_ROW) begin
        r = row + 16'd1;
        if (r == height_lim) return rssv_pkg::V_INVALID;
        if (nxt >= {1'b0, length_lim}) return rssv_pkg::V_INVALID;
        row = r;
        column = '0;
        pos = nxt[23:0];
        return rssv_pkg::V_CHECK;
      end
      col = column + {9'd0, b};
      if (col > {1'b0, width_lim}) return rssv_pkg::V_INVALID;
      if (nxt >= {1'b0, length_lim}) return rssv_pkg::V_INVALID;
      column = col;
      phase = rssv_pkg::PH_COUNT;
      pos = nxt[23:0];
      return rssv_pkg::V_CHECK;
    endfunction

    function void note_byte(logic start, logic [7:0] b);
      if (start) clear_image();
      if (verdict == rssv_pkg::V_CHECK) verdict = judge_byte(b);
      expected_verdicts.push_back(verdict);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 100) $display("mismatch: %s", msg);
    endtask

    task check_verdict(logic [1:0] got);
      rssv_pkg::verdict_t want;
      results_seen++;
      if (expected_verdicts.size() == 0) begin
        report($sformatf("verdict %0d with no byte pending", got));
      end else begin
        want = expected_verdicts.pop_front();
        if (got !== want)
          report($sformatf("verdict %0d for byte %0d, expected %0d", got, results_seen, want));
      end
    endtask
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_start_of_image = 1'b0;
  logic [7:0]  in_data_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_verdict;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [rssv_pkg::ADDR_W-1:0] paddr = '0;
  logic [rssv_pkg::DATA_W-1:0] pwdata = '0;
  logic [rssv_pkg::DATA_W-1:0] prdata;
  logic        pready;

  verdict_board board = new();
  bit [7:0]    sprite[$];
  int          items_sent = 0;
  int          send_idle_pct = 33;
  int          recv_stall_pct = 72;
  int          idle_cycles = 0;

  wire in_fire  = in_valid && !in_stall;
  wire out_fire = out_valid && !out_stall;

  rle_sprite_stream_validator_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_start_of_image(in_start_of_image),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_verdict      (out_verdict),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_fire) board.note_byte(in_start_of_image, in_data_byte);
      if (out_fire) board.check_verdict(out_verdict);
    end
  end

  always @(posedge clk) begin
    if (in_fire || out_fire) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task push_byte(logic start, logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_start_of_image <= start;
    in_data_byte <= b;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task push_sprite(bit with_start);
    foreach (sprite[i]) push_byte(with_start && (i == 0), sprite[i]);
  endtask

  task drain_results();
    in_valid <= 1'b0;
    while (board.results_seen < items_sent) @(posedge clk);
  endtask

  task reg_write(rssv_pkg::reg_idx_t idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // registers only change once the block has answered every pending request
  task set_regs(logic [15:0] w, logic [15:0] h, logic [23:0] l);
    drain_results();
    reg_write(rssv_pkg::REG_WIDTH, {16'd0, w});
    reg_write(rssv_pkg::REG_HEIGHT, {16'd0, h});
    reg_write(rssv_pkg::REG_LENGTH, {8'd0, l});
    board.set_limits(w, h, l);
  endtask

  // well-formed sprite: row markers stay below the height, runs stay inside the width
  function automatic void build_sprite(int unsigned w, int unsigned h);
    int unsigned col;
    int unsigned room;
    int unsigned lim;
    int unsigned s;
    int unsigned c;
    int unsigned markers;
    sprite.delete();
    markers = $urandom_range((h > 4) ? 3 : h - 1, 0);
    for (int r = 0; r <= markers; r++) begin
      if (r != 0) sprite.push_back(rssv_pkg::CODE_ROW);
      col = 0;
      repeat ($urandom_range(3)) begin
        room = w - col;
        lim = ($urandom_range(5) == 0) ? 253 : 6;
        if (lim > room) lim = room;
        s = $urandom_range(lim, 0);
        col += s;
        room = w - col;
        lim = ($urandom_range(11) == 0) ? 255 : 8;
        if (lim > room) lim = room;
        c = $urandom_range(lim, 0);
        col += c;
        sprite.push_back(s[7:0]);
        sprite.push_back(c[7:0]);
        repeat (c) sprite.push_back(8'($urandom_range(255)));
      end
    end
    sprite.push_back(rssv_pkg::CODE_END);
  endfunction

  initial begin
    int unsigned w;
    int unsigned h;
    int unsigned gw;
    int unsigned gh;
    int          len;
    int          k;
    int          rand_base;
    int          done;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // parse straight from reset without a start flag, then repeat the latched pass
    set_regs(16'd8, 16'd2, 24'd12);
    sprite = '{8'h02, 8'h03, 8'ha5, 8'h5a, 8'h00, 8'hfe, 8'h00, 8'h00, 8'hff, 8'h12};
    push_sprite(0);
    sprite = '{8'hfe, 8'hfe};          // row limit reached
    push_sprite(1);
    sprite = '{8'h09};                 // skip past the width
    push_sprite(1);
    sprite = '{8'h08, 8'h01};          // pixel count past the width
    push_sprite(1);
    set_regs(16'd8, 16'd2, 24'd4);
    sprite = '{8'h01, 8'h02, 8'hff, 8'h00};   // pixel run reaches the data end
    push_sprite(1);
    set_regs(16'd8, 16'd2, 24'd1);
    sprite = '{8'hfe};
    push_sprite(1);
    sprite = '{8'h05};
    push_sprite(1);
    sprite = '{8'hff};
    push_sprite(1);
    set_regs(16'd0, 16'd2, 24'd100);
    push_sprite(1);
    set_regs(16'hffff, 16'd0, 24'd100);
    push_sprite(1);
    set_regs(16'hffff, 16'hffff, 24'd0);
    push_sprite(1);
    set_regs(16'hffff, 16'hffff, 24'hffffff);
    sprite = '{8'hfd, 8'h00, 8'hff};
    push_sprite(1);

    rand_base = items_sent;
    done = 0;
    while (done < RANDOM_ITEMS) begin
      if (done < RANDOM_ITEMS / 3) begin
        send_idle_pct = 33;
        recv_stall_pct = 72;
      end else if (done < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 72;
        recv_stall_pct = 33;
      end else begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      k = $urandom_range(19);
      w = (k == 0) ? 0 : (k < 3) ? 16'hffff : $urandom_range(40, 1);
      k = $urandom_range(19);
      h = (k == 0) ? 0 : (k < 3) ? 16'hffff : $urandom_range(6, 1);
      gw = (w == 0) ? 8 : w;
      gh = (h == 0) ? 3 : h;
      if ($urandom_range(9) < 3) begin
        // data length right at the sprite's end, a little short or a little long
        build_sprite(gw, gh);
        len = sprite.size() + $urandom_range(4) - 2;
        if (len < 0) len = 0;
        set_regs(16'(w), 16'(h), 24'(len));
        push_sprite(1);
      end else begin
        len = $urandom_range(1) ? 24'hffffff : $urandom_range(24'hffffff, 4096);
        set_regs(16'(w), 16'(h), 24'(len));
        repeat ($urandom_range(6, 3)) begin
          k = $urandom_range(99);
          if (k < 6) begin
            repeat ($urandom_range(8, 1))
              push_byte(1'($urandom_range(1)), 8'($urandom_range(255)));
          end else begin
            build_sprite(gw, gh);
            if (k < 20) sprite[$urandom_range(sprite.size() - 1)] = 8'($urandom_range(255));
            else if (k < 28) sprite = sprite[0:$urandom_range(sprite.size() - 1)];
            push_sprite(!(k >= 28 && k < 34));
            if ($urandom_range(4) == 0) push_byte(1'b0, 8'($urandom_range(255)));
          end
        end
      end
      done = items_sent - rand_base;
    end

    drain_results();
    repeat (6) @(posedge clk);
    if (board.expected_verdicts.size() != 0)
      board.report($sformatf("%0d verdicts never arrived", board.expected_verdicts.size()));
    if (board.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
